/* design/bm_pkg.sv */
// shared constants, types and state codes for the boyer-moore search block
// no dependencies
package bm_pkg;

	localparam int PATTERN_MAX = 256;
	localparam int TEXT_MAX    = 1024;
	localparam int ALPHA       = 256;
	localparam int QDEPTH      = 4;

	localparam int PAW = $clog2(PATTERN_MAX);
	localparam int TAW = $clog2(TEXT_MAX);
	localparam int PCW = PAW + 1;
	localparam int TCW = TAW + 1;
	localparam int SW  = PCW;
	localparam int PIW = PCW + 1;
	localparam int TIW = TCW + 1;
	localparam int QAW = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		K_PAT_BYTE,
		K_PAT_LAST,
		K_TXT_BYTE,
		K_TXT_LAST
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_BC_FILL,
		ST_BC_RD,
		ST_BC_WR,
		ST_SUF_INIT,
		ST_SUF_CHK,
		ST_SUF_K,
		ST_SUF_ELSE,
		ST_SUF_G1,
		ST_SUF_G2,
		ST_SUF_G3,
		ST_SUF_SET,
		ST_GS_FILL,
		ST_GS1_RD,
		ST_GS1_CHK,
		ST_GS1_J,
		ST_GS1_JWR,
		ST_GS2_RD,
		ST_GS2_WR,
		ST_S_RD,
		ST_S_CMP,
		ST_S_SHIFT,
		ST_RES
	} state_t;

endpackage

/* design/boyer_moore_first_match.sv */
// top level of the boyer-moore first match search block
// depends on bm_pkg, bm_front, bm_back (and bm_ram below it)
//
// channel | signals                          | direction
// in      | in_valid/in_ready, action,       | byte transfer into the block
//         | data_byte, is_last               |
// out     | out_valid/out_ready, found,      | one result per closed text
//         | position                         |
//
// pattern and text bytes are taken one per cycle through a four entry queue, while it has room.
// the last pattern byte builds the tables: a bad-character fill, a pass over the
// pattern bytes, the suffix steps, and a good-suffix fill and the good-suffix passes.
// the last text byte runs the search: a read and a compare per byte, a shift step per mismatch.
// the queue keeps taking bytes while tables or the search run, until it is full; reset is async.
// a result waits in the output register until it is taken.
module boyer_moore_first_match (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   action,
	input  logic [7:0]             data_byte,
	input  logic                   is_last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   found,
	output logic [bm_pkg::TAW-1:0] position
);

	logic          q_valid;
	logic          q_pop;
	bm_pkg::item_t q_item;

	bm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .data_byte(data_byte), .is_last(is_last),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	bm_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready), .found(found), .position(position)
	);

`ifndef SYNTH
	// a miss always reports position zero
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (position == '0))
		else $error("miss with nonzero position");

	// the engine only pops a queued item
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	// a full queue is never empty
	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_valid)
		else $error("queue stalls while empty");
`endif

endmodule

/* design/bm_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module bm_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/bm_front.sv */
// front end: classifies incoming bytes and queues them for the engine
// depends on bm_pkg
module bm_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          action,
	input  logic [7:0]    data_byte,
	input  logic          is_last,
	output logic          q_valid,
	output bm_pkg::item_t q_item,
	input  logic          q_pop
);

	bm_pkg::item_t              mem_q [bm_pkg::QDEPTH];
	logic [bm_pkg::QAW-1:0]     wr_ptr_q;
	logic [bm_pkg::QAW-1:0]     rd_ptr_q;
	logic [bm_pkg::QAW:0]       count_q;
	logic                       push;
	bm_pkg::item_t              new_item;

	// classify the byte
	always_comb begin
		new_item.data = data_byte;
		case ({action, is_last})
			2'b00:   new_item.kind = bm_pkg::K_PAT_BYTE;
			2'b01:   new_item.kind = bm_pkg::K_PAT_LAST;
			2'b10:   new_item.kind = bm_pkg::K_TXT_BYTE;
			default: new_item.kind = bm_pkg::K_TXT_LAST;
		endcase
	end

	assign in_ready = (count_q != (bm_pkg::QAW+1)'(bm_pkg::QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/bm_back.sv */
// back end: stores bytes, builds the shift tables and runs the search
// depends on bm_pkg and bm_ram
module bm_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  bm_pkg::item_t          q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   found,
	output logic [bm_pkg::TAW-1:0] position
);

	bm_pkg::state_t state_q, state_d;

	logic [bm_pkg::PCW-1:0]        m_q, m_d;
	logic [bm_pkg::TCW-1:0]        n_q, n_d;
	logic                          pvalid_q, pvalid_d;
	logic signed [bm_pkg::PIW-1:0] i_q, i_d, g_q, g_d, f_q, f_d;
	logic [bm_pkg::PCW-1:0]        gj_q, gj_d, cnt_q, cnt_d;
	logic [7:0]                    pv_q, pv_d;
	logic signed [bm_pkg::TIW-1:0] sj_q, sj_d;
	logic                          res_found_q, res_found_d;
	logic [bm_pkg::TAW-1:0]        res_pos_q, res_pos_d;
	logic                          out_valid_q, out_valid_d;
	logic                          found_q, found_d;
	logic [bm_pkg::TAW-1:0]        position_q, position_d;

	// ram ports
	logic                   p_we, t_we, bc_we, gs_we, suf_we;
	logic [bm_pkg::PAW-1:0] p_waddr, p_raddr, gs_waddr, gs_raddr, suf_waddr, suf_raddr;
	logic [bm_pkg::TAW-1:0] t_waddr, t_raddr;
	logic [7:0]             bc_waddr, bc_raddr;
	logic [7:0]             p_wdata, t_wdata, p_rd, t_rd;
	logic [bm_pkg::SW-1:0]  bc_wdata, gs_wdata, suf_wdata, bc_rd, gs_rd, suf_rd;

	// shared terms
	logic signed [bm_pkg::PIW-1:0] m_s, m_m1, k_s, suf_s, gj_s, gs_s;
	logic [bm_pkg::PCW-1:0]        pat_base, m_new;
	logic [bm_pkg::TCW-1:0]        n_new;
	logic                          search_ok, out_free, suf_lt, gs1_hit, gj_more, bc_more;
	logic signed [bm_pkg::TIW-1:0] bc_sh, gs_sh, j_new, j_lim;

	assign m_s      = $signed({1'b0, m_q});
	assign m_m1     = m_s - 2'sd1;
	assign k_s      = i_q + m_m1 - f_q;
	assign suf_s    = $signed({1'b0, suf_rd});
	assign gj_s     = $signed({1'b0, gj_q});
	assign gs_s     = $signed({1'b0, gs_rd});
	assign pat_base = pvalid_q ? '0 : m_q;
	assign m_new    = (pat_base < bm_pkg::PCW'(bm_pkg::PATTERN_MAX)) ? pat_base + 1'b1 : pat_base;
	assign n_new    = (n_q < bm_pkg::TCW'(bm_pkg::TEXT_MAX)) ? n_q + 1'b1 : n_q;
	assign search_ok = pvalid_q && ((bm_pkg::TCW'(m_q)) <= n_new);
	assign out_free = !out_valid_q || out_ready;
	assign suf_lt   = suf_s < (i_q - g_q);
	assign gs1_hit  = suf_s == (i_q + 2'sd1);
	assign gj_more  = gj_s < (m_m1 - i_q);
	assign bc_more  = (i_q + 2'sd1) < m_m1;
	assign bc_sh    = bm_pkg::TIW'($signed({1'b0, bc_rd})) - bm_pkg::TIW'(m_s)
	                + bm_pkg::TIW'(i_q) + 2'sd1;
	assign gs_sh    = bm_pkg::TIW'(gs_s);
	assign j_new    = sj_q + ((bc_sh > gs_sh) ? bc_sh : gs_sh);
	assign j_lim    = $signed({1'b0, n_q}) - bm_pkg::TIW'(m_s);
	assign q_pop    = (state_q == bm_pkg::ST_IDLE) && q_valid;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bm_pkg::ST_IDLE: begin
				if (q_valid) begin
					if (q_item.kind == bm_pkg::K_PAT_LAST) begin
						state_d = bm_pkg::ST_BC_FILL;
					end else if (q_item.kind == bm_pkg::K_TXT_LAST) begin
						state_d = search_ok ? bm_pkg::ST_S_RD : bm_pkg::ST_RES;
					end
				end
			end
			bm_pkg::ST_BC_FILL: begin
				if (cnt_q == bm_pkg::PCW'(bm_pkg::ALPHA - 1)) begin
					state_d = (m_q > 1) ? bm_pkg::ST_BC_RD : bm_pkg::ST_SUF_INIT;
				end
			end
			bm_pkg::ST_BC_RD:   state_d = bm_pkg::ST_BC_WR;
			bm_pkg::ST_BC_WR:   state_d = bc_more ? bm_pkg::ST_BC_RD : bm_pkg::ST_SUF_INIT;
			bm_pkg::ST_SUF_INIT: begin
				state_d = (m_q == 1) ? bm_pkg::ST_GS_FILL : bm_pkg::ST_SUF_CHK;
			end
			bm_pkg::ST_SUF_CHK: state_d = (i_q > g_q) ? bm_pkg::ST_SUF_K : bm_pkg::ST_SUF_ELSE;
			bm_pkg::ST_SUF_K: begin
				if (suf_lt) begin
					state_d = (i_q == 0) ? bm_pkg::ST_GS_FILL : bm_pkg::ST_SUF_CHK;
				end else begin
					state_d = bm_pkg::ST_SUF_ELSE;
				end
			end
			bm_pkg::ST_SUF_ELSE: state_d = bm_pkg::ST_SUF_G1;
			bm_pkg::ST_SUF_G1:   state_d = (g_q < 0) ? bm_pkg::ST_SUF_SET : bm_pkg::ST_SUF_G2;
			bm_pkg::ST_SUF_G2:   state_d = bm_pkg::ST_SUF_G3;
			bm_pkg::ST_SUF_G3:   state_d = (pv_q == p_rd) ? bm_pkg::ST_SUF_G1 : bm_pkg::ST_SUF_SET;
			bm_pkg::ST_SUF_SET:  state_d = (i_q == 0) ? bm_pkg::ST_GS_FILL : bm_pkg::ST_SUF_CHK;
			bm_pkg::ST_GS_FILL: begin
				if (cnt_q == m_q - 1'b1) begin
					state_d = bm_pkg::ST_GS1_RD;
				end
			end
			bm_pkg::ST_GS1_RD:  state_d = bm_pkg::ST_GS1_CHK;
			bm_pkg::ST_GS1_CHK, bm_pkg::ST_GS1_J: begin
				if ((state_q == bm_pkg::ST_GS1_CHK && gs1_hit) ||
				    (state_q == bm_pkg::ST_GS1_J && gj_more)) begin
					state_d = (state_q == bm_pkg::ST_GS1_CHK) ? bm_pkg::ST_GS1_J
					                                          : bm_pkg::ST_GS1_JWR;
				end else if (i_q == 0) begin
					state_d = (m_q > 1) ? bm_pkg::ST_GS2_RD : bm_pkg::ST_IDLE;
				end else begin
					state_d = bm_pkg::ST_GS1_RD;
				end
			end
			bm_pkg::ST_GS1_JWR: state_d = bm_pkg::ST_GS1_J;
			bm_pkg::ST_GS2_RD:  state_d = bm_pkg::ST_GS2_WR;
			bm_pkg::ST_GS2_WR: begin
				state_d = (i_q == m_m1 - 2'sd1) ? bm_pkg::ST_IDLE : bm_pkg::ST_GS2_RD;
			end
			bm_pkg::ST_S_RD:    state_d = bm_pkg::ST_S_CMP;
			bm_pkg::ST_S_CMP: begin
				if (p_rd == t_rd) begin
					state_d = (i_q == 0) ? bm_pkg::ST_RES : bm_pkg::ST_S_RD;
				end else begin
					state_d = bm_pkg::ST_S_SHIFT;
				end
			end
			bm_pkg::ST_S_SHIFT: state_d = (j_new <= j_lim) ? bm_pkg::ST_S_RD : bm_pkg::ST_RES;
			bm_pkg::ST_RES:     state_d = out_free ? bm_pkg::ST_IDLE : bm_pkg::ST_RES;
			default:            state_d = bm_pkg::ST_IDLE;
		endcase
	end

	// datapath and ram controls
	always_comb begin
		m_d = m_q; n_d = n_q; pvalid_d = pvalid_q;
		i_d = i_q; g_d = g_q; f_d = f_q; gj_d = gj_q; cnt_d = cnt_q; pv_d = pv_q;
		sj_d = sj_q; res_found_d = res_found_q; res_pos_d = res_pos_q;
		out_valid_d = out_valid_q && !out_ready;
		found_d = found_q; position_d = position_q;
		p_we = 1'b0; t_we = 1'b0; bc_we = 1'b0; gs_we = 1'b0; suf_we = 1'b0;
		p_waddr = pat_base[bm_pkg::PAW-1:0]; p_wdata = q_item.data;
		t_waddr = n_q[bm_pkg::TAW-1:0]; t_wdata = q_item.data;
		p_raddr = i_q[bm_pkg::PAW-1:0];
		t_raddr = bm_pkg::TAW'(sj_q + bm_pkg::TIW'(i_q));
		bc_waddr = cnt_q[7:0]; bc_wdata = m_q; bc_raddr = t_rd;
		gs_waddr = cnt_q[bm_pkg::PAW-1:0]; gs_wdata = m_q; gs_raddr = i_q[bm_pkg::PAW-1:0];
		suf_waddr = i_q[bm_pkg::PAW-1:0]; suf_wdata = suf_rd; suf_raddr = i_q[bm_pkg::PAW-1:0];
		case (state_q)
			bm_pkg::ST_IDLE: begin
				if (q_valid) begin
					if (q_item.kind == bm_pkg::K_PAT_BYTE || q_item.kind == bm_pkg::K_PAT_LAST) begin
						p_we     = pat_base < bm_pkg::PCW'(bm_pkg::PATTERN_MAX);
						m_d      = m_new;
						pvalid_d = (q_item.kind == bm_pkg::K_PAT_LAST);
						cnt_d    = '0;
					end else begin
						t_we = n_q < bm_pkg::TCW'(bm_pkg::TEXT_MAX);
						n_d  = n_new;
						if (q_item.kind == bm_pkg::K_TXT_LAST) begin
							sj_d        = '0;
							i_d         = m_m1;
							res_found_d = 1'b0;
							res_pos_d   = '0;
						end
					end
				end
			end
			bm_pkg::ST_BC_FILL: begin
				bc_we = 1'b1;
				cnt_d = cnt_q + 1'b1;
				i_d   = '0;
			end
			bm_pkg::ST_BC_WR: begin
				bc_we    = 1'b1;
				bc_waddr = p_rd;
				bc_wdata = bm_pkg::SW'(m_m1 - i_q);
				i_d      = i_q + 2'sd1;
			end
			bm_pkg::ST_SUF_INIT: begin
				suf_we    = 1'b1;
				suf_waddr = m_m1[bm_pkg::PAW-1:0];
				suf_wdata = m_q;
				g_d       = m_m1;
				f_d       = m_m1;
				i_d       = m_m1 - 2'sd1;
				cnt_d     = '0;
			end
			bm_pkg::ST_SUF_CHK: suf_raddr = k_s[bm_pkg::PAW-1:0];
			bm_pkg::ST_SUF_K: begin
				if (suf_lt) begin
					suf_we = 1'b1;
					if (i_q != 0) begin
						i_d = i_q - 2'sd1;
					end
				end
			end
			bm_pkg::ST_SUF_ELSE: begin
				if (i_q < g_q) begin
					g_d = i_q;
				end
				f_d = i_q;
			end
			bm_pkg::ST_SUF_G1: p_raddr = g_q[bm_pkg::PAW-1:0];
			bm_pkg::ST_SUF_G2: begin
				pv_d    = p_rd;
				p_raddr = bm_pkg::PAW'(g_q + m_m1 - f_q);
			end
			bm_pkg::ST_SUF_G3: begin
				if (pv_q == p_rd) begin
					g_d = g_q - 2'sd1;
				end
			end
			bm_pkg::ST_SUF_SET: begin
				suf_we    = 1'b1;
				suf_wdata = bm_pkg::SW'(f_q - g_q);
				if (i_q != 0) begin
					i_d = i_q - 2'sd1;
				end
			end
			bm_pkg::ST_GS_FILL: begin
				gs_we = 1'b1;
				cnt_d = cnt_q + 1'b1;
				i_d   = m_m1;
				gj_d  = '0;
			end
			bm_pkg::ST_GS1_CHK, bm_pkg::ST_GS1_J: begin
				gs_raddr = gj_q[bm_pkg::PAW-1:0];
				if (!((state_q == bm_pkg::ST_GS1_CHK && gs1_hit) ||
				      (state_q == bm_pkg::ST_GS1_J && gj_more))) begin
					if (i_q != 0) begin
						i_d = i_q - 2'sd1;
					end
				end
			end
			bm_pkg::ST_GS1_JWR: begin
				gs_we    = (gs_rd == m_q);
				gs_waddr = gj_q[bm_pkg::PAW-1:0];
				gs_wdata = bm_pkg::SW'(m_m1 - i_q);
				gj_d     = gj_q + 1'b1;
			end
			bm_pkg::ST_GS2_WR: begin
				gs_we    = suf_s <= m_m1;
				gs_waddr = bm_pkg::PAW'(m_m1 - suf_s);
				gs_wdata = bm_pkg::SW'(m_m1 - i_q);
				i_d      = i_q + 2'sd1;
			end
			bm_pkg::ST_S_CMP: begin
				if (p_rd == t_rd) begin
					if (i_q == 0) begin
						res_found_d = 1'b1;
						res_pos_d   = sj_q[bm_pkg::TAW-1:0];
					end else begin
						i_d = i_q - 2'sd1;
					end
				end
			end
			bm_pkg::ST_S_SHIFT: begin
				sj_d = j_new;
				i_d  = m_m1;
			end
			bm_pkg::ST_RES: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					found_d     = res_found_q;
					position_d  = res_found_q ? res_pos_q : '0;
					n_d         = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bm_pkg::ST_IDLE;
			m_q         <= '0;
			n_q         <= '0;
			pvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			m_q         <= m_d;
			n_q         <= n_d;
			pvalid_q    <= pvalid_d;
			out_valid_q <= out_valid_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		i_q         <= i_d;
		g_q         <= g_d;
		f_q         <= f_d;
		gj_q        <= gj_d;
		cnt_q       <= cnt_d;
		pv_q        <= pv_d;
		sj_q        <= sj_d;
		res_found_q <= res_found_d;
		res_pos_q   <= res_pos_d;
		found_q     <= found_d;
		position_q  <= position_d;
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;

	// stores and tables
	bm_ram #(.Width(8), .Depth(bm_pkg::PATTERN_MAX)) u_pat (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rd)
	);
	bm_ram #(.Width(8), .Depth(bm_pkg::TEXT_MAX)) u_txt (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rd)
	);
	bm_ram #(.Width(bm_pkg::SW), .Depth(bm_pkg::ALPHA)) u_bc (
		.clk(clk), .we(bc_we), .waddr(bc_waddr), .wdata(bc_wdata), .raddr(bc_raddr),
		.rdata(bc_rd)
	);
	bm_ram #(.Width(bm_pkg::SW), .Depth(bm_pkg::PATTERN_MAX)) u_gs (
		.clk(clk), .we(gs_we), .waddr(gs_waddr), .wdata(gs_wdata), .raddr(gs_raddr),
		.rdata(gs_rd)
	);
	bm_ram #(.Width(bm_pkg::SW), .Depth(bm_pkg::PATTERN_MAX)) u_suf (
		.clk(clk), .we(suf_we), .waddr(suf_waddr), .wdata(suf_wdata), .raddr(suf_raddr),
		.rdata(suf_rd)
	);

endmodule

/* sim/boyer_moore_first_match_tb.sv */
// testbench for boyer_moore_first_match: pattern and text byte transfers in,
// first-match results out, checked against an in-bench boyer-moore predictor
// depends on bm_pkg and the boyer_moore_first_match rtl
`timescale 1ns / 100ps

class bm_match_board;
	logic [7:0] pat_mem [bm_pkg::PATTERN_MAX];
	logic [7:0] txt_mem [bm_pkg::TEXT_MAX];
	int bad_shift [bm_pkg::ALPHA];
	int good_shift [bm_pkg::PATTERN_MAX];
	int suf_len [bm_pkg::PATTERN_MAX];
	int pat_len;
	int txt_len;
	bit pat_closed;
	bit found_q [$];
	int pos_q [$];
	int errors;

	function new();
		pat_len = 0;
		txt_len = 0;
		pat_closed = 0;
		errors = 0;
	endfunction

	// suffix lengths of the pattern, right aligned
	function void build_suffix_lengths(int m);
		int g, f, k;
		g = m - 1;
		f = m - 1;
		suf_len[m - 1] = m;
		for (int i = m - 2; i >= 0; i--) begin
			k = i + m - 1 - f;
			if (i > g && k >= 0 && k < m && suf_len[k] < i - g) begin
				suf_len[i] = suf_len[k];
			end else begin
				if (i < g)
					g = i;
				f = i;
				while (g >= 0 && pat_mem[g] == pat_mem[g + m - 1 - f])
					g--;
				suf_len[i] = f - g;
			end
		end
	endfunction

	function void build_shift_tables(int m);
		int j, k;
		for (int i = 0; i < bm_pkg::ALPHA; i++)
			bad_shift[i] = m;
		for (int i = 0; i < m - 1; i++)
			bad_shift[pat_mem[i]] = m - 1 - i;
		build_suffix_lengths(m);
		for (int i = 0; i < m; i++)
			good_shift[i] = m;
		j = 0;
		for (int i = m - 1; i >= 0; i--) begin
			if (suf_len[i] == i + 1) begin
				for (; j < m - i - 1; j++)
					if (good_shift[j] == m)
						good_shift[j] = m - i - 1;
			end
		end
		for (int i = 0; i <= m - 2; i++) begin
			k = m - 1 - suf_len[i];
			if (k >= 0 && k < m)
				good_shift[k] = m - i - 1;
		end
	endfunction

	function bit search_first(int m, int n, output int pos);
		int j, i, bc, gs;
		pos = 0;
		if (m < 1 || m > n)
			return 0;
		j = 0;
		while (j <= n - m) begin
			i = m - 1;
			while (i >= 0 && pat_mem[i] == txt_mem[i + j])
				i--;
			if (i < 0) begin
				pos = j;
				return 1;
			end
			bc = bad_shift[txt_mem[i + j]] - m + i + 1;
			gs = good_shift[i];
			j += (bc > gs) ? bc : gs;
		end
		return 0;
	endfunction

	// note one accepted input transfer
	function void note_byte(bit is_text, logic [7:0] b, bit last);
		int pos;
		bit hit;
		if (!is_text) begin
			if (pat_closed) begin
				pat_closed = 0;
				pat_len = 0;
			end
			if (pat_len < bm_pkg::PATTERN_MAX) begin
				pat_mem[pat_len] = b;
				pat_len++;
			end
			if (last) begin
				build_shift_tables(pat_len);
				pat_closed = 1;
			end
			return;
		end
		if (txt_len < bm_pkg::TEXT_MAX) begin
			txt_mem[txt_len] = b;
			txt_len++;
		end
		if (!last)
			return;
		hit = 0;
		pos = 0;
		if (pat_closed)
			hit = search_first(pat_len, txt_len, pos);
		txt_len = 0;
		found_q.push_back(hit);
		pos_q.push_back(hit ? pos : 0);
	endfunction

	// compare one result transfer against the oldest expectation
	function void check_result(logic f, logic [bm_pkg::TAW-1:0] p);
		bit ef;
		int ep;
		if (found_q.size() == 0) begin
			$display("%0t: unexpected result found=%0d position=%0d", $time, f, p);
			errors++;
			return;
		end
		ef = found_q.pop_front();
		ep = pos_q.pop_front();
		if (f !== ef) begin
			$display("%0t: found expected %0d actual %0d", $time, ef, f);
			errors++;
		end
		if (p !== ep[bm_pkg::TAW-1:0]) begin
			$display("%0t: position expected %0d actual %0d", $time, ep, p);
			errors++;
		end
	endfunction
endclass

module boyer_moore_first_match_tb;
	localparam int STALL_LIMIT = 200000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic action = 0;
	logic [7:0] data_byte = 0;
	logic is_last = 0;
	logic out_valid;
	logic out_ready = 0;
	logic found;
	logic [bm_pkg::TAW-1:0] position;

	bm_match_board board = new();
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int quiet_cycles = 0;
	logic [7:0] pat_buf [$];
	logic [7:0] txt_buf [$];

	boyer_moore_first_match i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .data_byte(data_byte), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .position(position)
	);

	// clock
	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// result side: random stalls, check each transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(found, position);
		out_ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one input transfer, with random idle cycles ahead of it
	task automatic send_byte(bit is_text, logic [7:0] b, bit last);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		action <= is_text;
		data_byte <= b;
		is_last <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_byte(is_text, b, last);
	endtask

	task automatic send_pattern(int len, int alpha);
		pat_buf.delete();
		for (int i = 0; i < len; i++) begin
			pat_buf.push_back(8'($urandom_range(alpha - 1)));
			send_byte(0, pat_buf[i], i == len - 1);
		end
	endtask

	// text of random bytes, sometimes with the current pattern planted in it
	task automatic send_text(int len, int alpha, bit plant);
		int at;
		txt_buf.delete();
		for (int i = 0; i < len; i++)
			txt_buf.push_back(8'($urandom_range(alpha - 1)));
		if (plant && pat_buf.size() > 0 && pat_buf.size() <= len) begin
			at = $urandom_range(len - pat_buf.size());
			for (int i = 0; i < pat_buf.size(); i++)
				txt_buf[at + i] = pat_buf[i];
		end
		for (int i = 0; i < len; i++)
			send_byte(1, txt_buf[i], i == len - 1);
	endtask

	task automatic random_phase(int n_items);
		int sent, plen, tlen, alpha;
		sent = 0;
		while (sent < n_items) begin
			alpha = ($urandom_range(3) == 0) ? 256 : $urandom_range(2, 4);
			if ($urandom_range(3) != 0 || pat_buf.size() == 0) begin
				plen = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
				send_pattern(plen, alpha);
				sent += plen;
			end
			tlen = ($urandom_range(19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
			send_text(tlen, alpha, $urandom_range(1));
			sent += tlen;
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// no closed pattern yet
		send_text(3, 256, 0);
		// single byte pattern at the byte extremes
		pat_buf = {8'h00};
		send_byte(0, 8'h00, 1);
		send_byte(1, 8'hff, 0);
		send_byte(1, 8'h00, 1);
		pat_buf = {8'hff};
		send_byte(0, 8'hff, 1);
		send_byte(1, 8'hff, 1);
		// pattern longer than text
		send_pattern(5, 2);
		send_text(3, 2, 0);
		// repetitive pattern, good-suffix heavy
		send_pattern(4, 2);
		send_text(10, 2, 1);

		src_idle_pct = 25;
		snk_idle_pct = 60;
		random_phase(250);
		src_idle_pct = 60;
		snk_idle_pct = 25;
		random_phase(250);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_phase(200);

		// overflow of both stores, the last byte dropped but still closing
		send_pattern(bm_pkg::PATTERN_MAX + 2, 2);
		send_text(bm_pkg::TEXT_MAX + 2, 2, 1);
		in_valid <= 0;

		while (board.found_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.found_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
